// ===== sv/cap_pkg.sv =====
// Package for the comb and all-pass reverb: word types, fixed-point limits,
// register indexes and the rounding and saturation helpers.
// No dependencies.
package cap_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [23:0] word_t;
    typedef logic        [15:0] gain_t;
    typedef logic signed [40:0] prod_t;

    typedef enum logic [1:0] {
        REG_COMB_GAIN    = 2'd0,
        REG_WET_MIX      = 2'd1,
        REG_ALLPASS_GAIN = 2'd2
    } cfg_reg_t;

    localparam int    NUM_COMBS = 4;
    localparam gain_t ONE_Q15 = 16'h8000;
    localparam gain_t COMB_GAIN_RST = 16'd26214;
    localparam gain_t WET_MIX_RST = 16'd16384;
    localparam gain_t ALLPASS_GAIN_RST = 16'd22938;
    localparam word_t W24_MAX = 24'sh7FFFFF;
    localparam word_t W24_MIN = -24'sh800000;
    localparam sample_t S16_MAX = 16'sh7FFF;
    localparam sample_t S16_MIN = -16'sh8000;

    function automatic gain_t clamp_gain(input gain_t v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    function automatic logic signed [25:0] rnd_q15(input prod_t p);
        prod_t t;
        t = p + 41'sd16384;
        return t[40:15];
    endfunction

    function automatic word_t sat24(input logic signed [26:0] v);
        if ((v[26:23] == 4'b0000) || (v[26:23] == 4'b1111))
        begin
            return v[23:0];
        end
        return v[26] ? W24_MIN : W24_MAX;
    endfunction

    function automatic sample_t sat16(input logic signed [26:0] v);
        if ((v[26:15] == 12'h000) || (v[26:15] == 12'hFFF))
        begin
            return v[15:0];
        end
        return v[26] ? S16_MIN : S16_MAX;
    endfunction

endpackage

// ===== sv/comb_allpass_reverb.sv =====
// Reverb with four feedback comb lines, one all-pass stage and a wet/dry mix.
// Depends on cap_pkg for types, limits and the rounding helpers.
//
// Usage: one signed Q1.15 sample enters on the input channel per
// transaction (in_valid high, in_stall low at a rising edge) and exactly one
// mixed sample leaves on the output channel per transaction (out_valid high,
// out_stall low). Samples stay in order.
// A sample passes the registered stages s1, s2, s3 and s4 and then the output
// register on its way to out_valid. A new sample is taken every cycle while
// in_stall is low; each delay-line memory does one read and one write per sample.
// While out_valid is high and out_stall is high, the whole pipeline holds
// and in_stall is raised; nothing is lost or repeated.
// After reset the delay lines are cleared, one entry of every line per cycle,
// until all entries of the longest line (1356 with the default lengths) are
// cleared; in_stall stays high during this pass. Gains above 1.0 are clamped.
// Gains are written on the config channel (cfg_ready is always high); the
// user must do so only while no sample is in flight; the block does not check.
module comb_allpass_reverb #(
    parameter int COMB_LEN_A  = 1116,
    parameter int COMB_LEN_B  = 1188,
    parameter int COMB_LEN_C  = 1277,
    parameter int COMB_LEN_D  = 1356,
    parameter int ALLPASS_LEN = 225
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  cap_pkg::sample_t sample_in,
    output logic             out_valid,
    input  logic             out_stall,
    output cap_pkg::sample_t sample_out,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  cap_pkg::gain_t   cfg_data
);
    import cap_pkg::*;

    localparam int COMB_LEN [NUM_COMBS] = '{COMB_LEN_A, COMB_LEN_B, COMB_LEN_C, COMB_LEN_D};
    localparam int MAX_AB = (COMB_LEN_A > COMB_LEN_B) ? COMB_LEN_A : COMB_LEN_B;
    localparam int MAX_CD = (COMB_LEN_C > COMB_LEN_D) ? COMB_LEN_C : COMB_LEN_D;
    localparam int MAX_COMB = (MAX_AB > MAX_CD) ? MAX_AB : MAX_CD;
    localparam int CLR_LEN = (MAX_COMB > ALLPASS_LEN) ? MAX_COMB : ALLPASS_LEN;
    localparam int CLR_W = $clog2(CLR_LEN + 1);
    localparam int AP_AW = $clog2(ALLPASS_LEN);

    gain_t comb_gain_reg;
    gain_t wet_mix_reg;
    gain_t allpass_gain_reg;

    logic             clr_busy_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    logic adv;
    logic acc;

    logic s1_v_reg;
    logic s2_v_reg;
    logic s3_v_reg;
    logic s4_v_reg;
    logic out_valid_reg;

    sample_t s1_x_reg;
    sample_t s2_x_reg;
    sample_t s3_x_reg;
    word_t   s1_d_reg [NUM_COMBS];
    word_t   s2_avg_reg;
    word_t   s3_avg_reg;
    word_t   s3_y_reg;
    word_t   y_next;
    prod_t   s4_pw_reg;
    logic signed [32:0] s4_pd_reg;
    sample_t sample_out_reg;

    logic [AP_AW-1:0] ap_pos_reg;
    logic [AP_AW-1:0] ap_pos_next;
    logic [AP_AW-1:0] s1_ap_pos_reg;
    logic [AP_AW-1:0] s2_ap_pos_reg;
    logic [AP_AW-1:0] s3_ap_pos_reg;
    logic [AP_AW-1:0] ap_waddr;
    word_t            ap_mem [ALLPASS_LEN];
    word_t            s2_apd_reg;
    word_t            s2_bypd_reg;
    logic             s2_byp_reg;
    word_t            apd;
    word_t            ap_wdata;
    word_t            ap_mem_wdata;
    logic             ap_we;
    prod_t            ap_prod_a;
    prod_t            ap_prod_b;

    logic signed [25:0] tap_total;
    gain_t              dry_share;
    prod_t              pw_next;
    logic signed [32:0] pd_next;
    logic signed [41:0] mix_sum;

    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = clr_busy_reg || !adv;
    assign acc       = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sample_out = sample_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_gain_reg    <= COMB_GAIN_RST;
            wet_mix_reg      <= WET_MIX_RST;
            allpass_gain_reg <= ALLPASS_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COMB_GAIN:    comb_gain_reg    <= clamp_gain(cfg_data);
                REG_WET_MIX:      wet_mix_reg      <= clamp_gain(cfg_data);
                REG_ALLPASS_GAIN: allpass_gain_reg <= clamp_gain(cfg_data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == CLR_W'(CLR_LEN - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ap_pos_reg    <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_v_reg      <= acc;
                s2_v_reg      <= s1_v_reg;
                s3_v_reg      <= s2_v_reg;
                s4_v_reg      <= s3_v_reg;
                out_valid_reg <= s4_v_reg;
            end
            if (acc)
            begin
                ap_pos_reg <= ap_pos_next;
            end
        end
    end

    for (genvar i = 0; i < NUM_COMBS; i++)
    begin : g_comb
        localparam int LEN = COMB_LEN[i];
        localparam int AW = $clog2(LEN);

        word_t         mem [LEN];
        logic [AW-1:0] pos_reg;
        logic [AW-1:0] pos_next;
        logic [AW-1:0] s1_pos_reg;
        logic [AW-1:0] waddr;
        word_t         wdata;
        word_t         mem_wdata;
        logic          we;
        prod_t         prod;

        always_comb
        begin
            if (pos_reg == AW'(LEN - 1))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
            prod = s1_d_reg[i] * $signed({1'b0, comb_gain_reg});
            wdata = sat24(27'(s1_x_reg) + 27'(rnd_q15(prod)));
            if (clr_busy_reg)
            begin
                we        = clr_cnt_reg < CLR_W'(LEN);
                waddr     = clr_cnt_reg[AW-1:0];
                mem_wdata = '0;
            end
            else
            begin
                we        = adv && s1_v_reg;
                waddr     = s1_pos_reg;
                mem_wdata = wdata;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pos_reg <= '0;
            end
            else if (acc)
            begin
                pos_reg <= pos_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[waddr] <= mem_wdata;
            end
            if (adv)
            begin
                s1_d_reg[i] <= mem[pos_reg];
                s1_pos_reg  <= pos_reg;
            end
        end
    end

    always_comb
    begin
        if (ap_pos_reg == AP_AW'(ALLPASS_LEN - 1))
        begin
            ap_pos_next = '0;
        end
        else
        begin
            ap_pos_next = ap_pos_reg + 1'b1;
        end

        tap_total = 26'(s1_d_reg[0]) + 26'(s1_d_reg[1]) + 26'(s1_d_reg[2])
                  + 26'(s1_d_reg[3]);

        apd       = s2_byp_reg ? s2_bypd_reg : s2_apd_reg;
        ap_prod_a = s2_avg_reg * $signed({1'b0, allpass_gain_reg});
        y_next    = sat24(27'(apd) - 27'(rnd_q15(ap_prod_a)));

        ap_prod_b = s3_y_reg * $signed({1'b0, allpass_gain_reg});
        ap_wdata  = sat24(27'(s3_avg_reg) + 27'(rnd_q15(ap_prod_b)));
        dry_share = ONE_Q15 - wet_mix_reg;
        pw_next   = s3_y_reg * $signed({1'b0, wet_mix_reg});
        pd_next   = s3_x_reg * $signed({1'b0, dry_share});

        mix_sum = 42'(s4_pw_reg) + 42'(s4_pd_reg) + 42'sd16384;

        if (clr_busy_reg)
        begin
            ap_we        = clr_cnt_reg < CLR_W'(ALLPASS_LEN);
            ap_waddr     = clr_cnt_reg[AP_AW-1:0];
            ap_mem_wdata = '0;
        end
        else
        begin
            ap_we        = adv && s3_v_reg;
            ap_waddr     = s3_ap_pos_reg;
            ap_mem_wdata = ap_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ap_we)
        begin
            ap_mem[ap_waddr] <= ap_mem_wdata;
        end
        if (adv)
        begin
            s2_apd_reg <= ap_mem[s1_ap_pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg       <= sample_in;
            s1_ap_pos_reg  <= ap_pos_reg;
            s2_x_reg       <= s1_x_reg;
            s2_avg_reg     <= tap_total[25:2];
            s2_ap_pos_reg  <= s1_ap_pos_reg;
            s2_byp_reg     <= s3_v_reg && (s3_ap_pos_reg == s1_ap_pos_reg);
            s2_bypd_reg    <= ap_wdata;
            s3_x_reg       <= s2_x_reg;
            s3_avg_reg     <= s2_avg_reg;
            s3_y_reg       <= y_next;
            s3_ap_pos_reg  <= s2_ap_pos_reg;
            s4_pw_reg      <= pw_next;
            s4_pd_reg      <= pd_next;
            sample_out_reg <= sat16(mix_sum[41:15]);
        end
    end

`ifndef SYNTH
    a_clear_leaves_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> (!s1_v_reg && !s4_v_reg && !out_valid_reg))
        else $error("clear pass ended with samples in flight");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> ($stable(s1_v_reg) && $stable(s4_v_reg)))
        else $error("pipeline moved while output was stalled");

    a_last_stage_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_v_reg && adv) |=> out_valid_reg)
        else $error("sample dropped between last stage and output");

    a_ap_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ap_pos_reg) < ALLPASS_LEN)
        else $error("all-pass position out of range");

    a_gain_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (comb_gain_reg <= ONE_Q15) && (wet_mix_reg <= ONE_Q15)
        && (allpass_gain_reg <= ONE_Q15))
        else $error("gain register above one");
`endif

endmodule
